// ===== rtl/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg: shared types and constants for the midpoint line rasterizer
// Slope case codes, the command word passed from the front end to the
// stepping engine, and the fixed field widths of the frame interface.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COLOR_BITS     = 24;
    localparam int ADDR_BITS      = 24;
    localparam int DEC_BITS       = 20;
    localparam int INC_BITS       = 19;
    localparam int DIM_BITS       = 13;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        SLOPE_FLAT         = 3'd0,
        SLOPE_STEEP_UP     = 3'd1,
        SLOPE_SHALLOW_UP   = 3'd2,
        SLOPE_SHALLOW_DOWN = 3'd3,
        SLOPE_STEEP_DOWN   = 3'd4
    } slope_t;

    typedef struct packed {
        logic                         is_step;
        logic                         starts_active;
        slope_t                       slope;
        logic signed [DEC_BITS-1:0]   decision;
        logic signed [INC_BITS-1:0]   inc_straight;
        logic signed [INC_BITS-1:0]   inc_diagonal;
        logic [COLOR_BITS-1:0]        color;
    } cmd_ctrl_t;

    typedef struct packed {
        logic we_ok;
        logic last;
    } pix_flags_t;

endpackage

// ===== rtl/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer: integer midpoint line rasterizer
// throughput: one request per cycle unless m_tready stalls; each stage (setup,
//   queue, stepping engine, address multiplier) takes one request per clock
// reset: aresetn clears all valids, line state to zero, width 640, height 480
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer #(
    parameter  int COORD_BITS = 16,
    localparam int IN_BITS    = ((4 * COORD_BITS + mlr_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   =
        ((2 * COORD_BITS + mlr_pkg::ADDR_BITS + mlr_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_row, start_col, end_row, end_col, pixel_color
    input  logic [IN_BITS-1:0]                  s_tdata,
    // op
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_row, out_col, frame_address, out_color
    output logic [OUT_BITS-1:0]                 m_tdata,
    // write_enable
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [mlr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mlr_pkg::DIM_BITS-1:0]        cfg_wdata
);
    import mlr_pkg::*;

    localparam int CMD_BITS = $bits(cmd_ctrl_t) + 3 * COORD_BITS;

    logic [DIM_BITS-1:0] width_reg, height_reg;

    logic                         f_valid, f_ready;
    cmd_ctrl_t                    f_ctrl;
    logic signed [COORD_BITS-1:0] f_row, f_col, f_stop;
    logic [CMD_BITS-1:0]          q_wr_data, q_rd_data;
    logic                         q_valid, q_ready;
    cmd_ctrl_t                    q_ctrl;
    logic signed [COORD_BITS-1:0] q_row, q_col, q_stop;

    logic                         p_valid, p_ready;
    logic signed [COORD_BITS-1:0] p_row, p_col;
    logic [COLOR_BITS-1:0]        p_color;
    pix_flags_t                   p_flags;

    logic signed [COORD_BITS-1:0] o_row, o_col;
    logic [ADDR_BITS-1:0]         o_addr;
    logic [COLOR_BITS-1:0]        o_color;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_WIDTH) begin
                width_reg <= cfg_wdata;
            end else if (cfg_index == CFG_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
        end
    end

    mlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_step   (s_tuser == OP_STEP),
        .in_row1   (s_tdata[0 * COORD_BITS +: COORD_BITS]),
        .in_col1   (s_tdata[1 * COORD_BITS +: COORD_BITS]),
        .in_row2   (s_tdata[2 * COORD_BITS +: COORD_BITS]),
        .in_col2   (s_tdata[3 * COORD_BITS +: COORD_BITS]),
        .in_color  (s_tdata[4 * COORD_BITS +: COLOR_BITS]),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_ctrl  (f_ctrl),
        .cmd_row   (f_row),
        .cmd_col   (f_col),
        .cmd_stop  (f_stop)
    );

    assign q_wr_data = {f_ctrl, f_stop, f_col, f_row};

    mlr_queue #(
        .DATA_BITS (CMD_BITS),
        .DEPTH     (2)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rd_data)
    );

    assign {q_ctrl, q_stop, q_col, q_row} = q_rd_data;

    mlr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_ctrl  (q_ctrl),
        .cmd_row   (q_row),
        .cmd_col   (q_col),
        .cmd_stop  (q_stop),
        .pix_valid (p_valid),
        .pix_ready (p_ready),
        .pix_row   (p_row),
        .pix_col   (p_col),
        .pix_color (p_color),
        .pix_flags (p_flags)
    );

    mlr_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pix_valid     (p_valid),
        .pix_ready     (p_ready),
        .pix_row       (p_row),
        .pix_col       (p_col),
        .pix_color     (p_color),
        .pix_flags     (p_flags),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_row       (o_row),
        .out_col       (o_col),
        .out_addr      (o_addr),
        .out_color     (o_color),
        .out_we        (m_tuser),
        .out_last      (m_tlast)
    );

    assign m_tdata = OUT_BITS'({o_color, o_addr, o_col, o_row});

endmodule

// ===== rtl/mlr_front.sv =====
// ----------------------------------------------------------------------------
// mlr_front: request intake and line setup
// Orders the endpoints and forms the deltas in one register stage, then
// classifies the slope and seeds the decision variable on the way into the
// command queue.
// ----------------------------------------------------------------------------
module mlr_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_step,
    input  logic signed [COORD_BITS-1:0]      in_row1,
    input  logic signed [COORD_BITS-1:0]      in_col1,
    input  logic signed [COORD_BITS-1:0]      in_row2,
    input  logic signed [COORD_BITS-1:0]      in_col2,
    input  logic [mlr_pkg::COLOR_BITS-1:0]    in_color,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output mlr_pkg::cmd_ctrl_t                cmd_ctrl,
    output logic signed [COORD_BITS-1:0]      cmd_row,
    output logic signed [COORD_BITS-1:0]      cmd_col,
    output logic signed [COORD_BITS-1:0]      cmd_stop
);
    import mlr_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int EXT_BITS  = COORD_BITS + 3;

    logic                         valid_reg;
    logic                         step_reg;
    logic signed [COORD_BITS-1:0] row1_reg, col1_reg, row2_reg, col2_reg;
    logic signed [DIFF_BITS-1:0]  dr_reg, dc_reg;
    logic [COLOR_BITS-1:0]        color_reg;

    logic                         swap;
    logic signed [COORD_BITS-1:0] a_row, a_col, b_row, b_col;
    logic signed [DIFF_BITS-1:0]  a_row_x, a_col_x, b_row_x, b_col_x;
    logic signed [DIFF_BITS-1:0]  dr_next, dc_next;
    logic                         load;

    logic signed [EXT_BITS-1:0]   dr_x, dc_x;
    logic signed [EXT_BITS-1:0]   d0, inc_s, inc_g;
    slope_t                       slope;

    // endpoint with the smaller row first, then the smaller column
    assign swap = (in_row2 < in_row1) || ((in_row2 == in_row1) && (in_col2 < in_col1));
    assign a_row = swap ? in_row2 : in_row1;
    assign a_col = swap ? in_col2 : in_col1;
    assign b_row = swap ? in_row1 : in_row2;
    assign b_col = swap ? in_col1 : in_col2;

    assign a_row_x = DIFF_BITS'(a_row);
    assign a_col_x = DIFF_BITS'(a_col);
    assign b_row_x = DIFF_BITS'(b_row);
    assign b_col_x = DIFF_BITS'(b_col);
    assign dr_next = b_row_x - a_row_x;
    assign dc_next = b_col_x - a_col_x;

    assign in_ready  = !valid_reg || cmd_ready;
    assign load      = in_valid && in_ready;
    assign cmd_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (load) begin
            step_reg  <= in_step;
            row1_reg  <= a_row;
            col1_reg  <= a_col;
            row2_reg  <= b_row;
            col2_reg  <= b_col;
            dr_reg    <= dr_next;
            dc_reg    <= dc_next;
            color_reg <= in_color;
        end
    end

    assign dr_x = EXT_BITS'(dr_reg);
    assign dc_x = EXT_BITS'(dc_reg);

    always_comb begin
        slope    = SLOPE_FLAT;
        d0       = '0;
        inc_s    = '0;
        inc_g    = '0;
        cmd_stop = col2_reg;
        if (dr_reg == '0) begin
            slope = SLOPE_FLAT;
        end else if (dc_x > dr_x) begin
            slope = SLOPE_STEEP_UP;
            d0    = dc_x - dr_x - dr_x;
            inc_s = -(dr_x + dr_x);
            inc_g = (dc_x - dr_x) + (dc_x - dr_x);
        end else if (dc_x > 0) begin
            slope    = SLOPE_SHALLOW_UP;
            d0       = dc_x + dc_x - dr_x;
            inc_s    = dc_x + dc_x;
            inc_g    = (dc_x - dr_x) + (dc_x - dr_x);
            cmd_stop = row2_reg;
        end else if ((dc_x + dr_x) > 0) begin
            slope    = SLOPE_SHALLOW_DOWN;
            d0       = dr_x + dc_x + dc_x;
            inc_s    = dc_x + dc_x;
            inc_g    = (dr_x + dc_x) + (dr_x + dc_x);
            cmd_stop = row2_reg;
        end else begin
            slope = SLOPE_STEEP_DOWN;
            d0    = dr_x + dr_x + dc_x;
            inc_s = dr_x + dr_x;
            inc_g = (dr_x + dc_x) + (dr_x + dc_x);
        end
    end

    always_comb begin
        cmd_ctrl.is_step       = step_reg;
        cmd_ctrl.starts_active = !((dr_reg == '0) && (dc_reg == '0));
        cmd_ctrl.slope         = slope;
        cmd_ctrl.decision      = DEC_BITS'(d0);
        cmd_ctrl.inc_straight  = INC_BITS'(inc_s);
        cmd_ctrl.inc_diagonal  = INC_BITS'(inc_g);
        cmd_ctrl.color         = color_reg;
    end

    assign cmd_row = row1_reg;
    assign cmd_col = col1_reg;

endmodule

// ===== rtl/mlr_queue.sv =====
// ----------------------------------------------------------------------------
// mlr_queue: command queue between setup and stepping
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mlr_queue #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output logic [DATA_BITS-1:0] rd_data
);
    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0]  mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  push, pop;

    assign wr_ready = (count_reg != COUNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/mlr_back.sv =====
// ----------------------------------------------------------------------------
// mlr_back: midpoint stepping engine
// Holds the line state, one command per cycle unless pix_ready stalls; a load
// seeds it, an active step moves one pixel and updates a non-flat decision.
// ----------------------------------------------------------------------------
module mlr_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  mlr_pkg::cmd_ctrl_t                cmd_ctrl,
    input  logic signed [COORD_BITS-1:0]      cmd_row,
    input  logic signed [COORD_BITS-1:0]      cmd_col,
    input  logic signed [COORD_BITS-1:0]      cmd_stop,
    output logic                              pix_valid,
    input  logic                              pix_ready,
    output logic signed [COORD_BITS-1:0]      pix_row,
    output logic signed [COORD_BITS-1:0]      pix_col,
    output logic [mlr_pkg::COLOR_BITS-1:0]    pix_color,
    output mlr_pkg::pix_flags_t               pix_flags
);
    import mlr_pkg::*;

    logic signed [COORD_BITS-1:0] cur_row_reg, cur_row_next;
    logic signed [COORD_BITS-1:0] cur_col_reg, cur_col_next;
    logic signed [COORD_BITS-1:0] stop_reg, stop_next;
    logic signed [DEC_BITS-1:0]   dec_reg, dec_next;
    logic signed [INC_BITS-1:0]   inc_s_reg, inc_s_next;
    logic signed [INC_BITS-1:0]   inc_g_reg, inc_g_next;
    slope_t                       slope_reg, slope_next;
    logic [COLOR_BITS-1:0]        color_reg, color_next;
    logic                         active_reg, active_next;
    logic                         valid_reg, valid_next;
    pix_flags_t                   flags_reg, flags_next;

    logic                         take;
    logic                         diag;
    logic signed [COORD_BITS-1:0] row_adv, col_adv;
    logic signed [DEC_BITS-1:0]   dec_adv;
    logic                         last_adv;

    assign cmd_ready = !valid_reg || pix_ready;
    assign take      = cmd_valid && cmd_ready;

    // one midpoint step from the held state
    always_comb begin
        diag    = 1'b0;
        row_adv = cur_row_reg;
        col_adv = cur_col_reg;
        case (slope_reg)
            SLOPE_FLAT: begin
                col_adv = cur_col_reg + 1'b1;
            end
            SLOPE_STEEP_UP: begin
                diag    = !(dec_reg > 0);
                col_adv = cur_col_reg + 1'b1;
                row_adv = cur_row_reg + COORD_BITS'(diag);
            end
            SLOPE_SHALLOW_UP: begin
                diag    = !(dec_reg < 0);
                row_adv = cur_row_reg + 1'b1;
                col_adv = cur_col_reg + COORD_BITS'(diag);
            end
            SLOPE_SHALLOW_DOWN: begin
                diag    = !(dec_reg > 0);
                row_adv = cur_row_reg + 1'b1;
                col_adv = cur_col_reg - COORD_BITS'(diag);
            end
            default: begin
                diag    = !(dec_reg < 0);
                col_adv = cur_col_reg - 1'b1;
                row_adv = cur_row_reg + COORD_BITS'(diag);
            end
        endcase
        if (slope_reg == SLOPE_FLAT) begin
            dec_adv = dec_reg;
        end else begin
            dec_adv = dec_reg + (diag ? DEC_BITS'(inc_g_reg) : DEC_BITS'(inc_s_reg));
        end
        if ((slope_reg == SLOPE_SHALLOW_UP) || (slope_reg == SLOPE_SHALLOW_DOWN)) begin
            last_adv = (row_adv == stop_reg);
        end else begin
            last_adv = (col_adv == stop_reg);
        end
    end

    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        stop_next    = stop_reg;
        dec_next     = dec_reg;
        inc_s_next   = inc_s_reg;
        inc_g_next   = inc_g_reg;
        slope_next   = slope_reg;
        color_next   = color_reg;
        active_next  = active_reg;
        flags_next   = flags_reg;
        valid_next   = cmd_ready ? cmd_valid : valid_reg;
        if (take) begin
            if (!cmd_ctrl.is_step) begin
                cur_row_next = cmd_row;
                cur_col_next = cmd_col;
                stop_next    = cmd_stop;
                dec_next     = cmd_ctrl.decision;
                inc_s_next   = cmd_ctrl.inc_straight;
                inc_g_next   = cmd_ctrl.inc_diagonal;
                slope_next   = cmd_ctrl.slope;
                color_next   = cmd_ctrl.color;
                active_next  = cmd_ctrl.starts_active;
                flags_next   = '{we_ok: 1'b1, last: !cmd_ctrl.starts_active};
            end else if (!active_reg) begin
                // idle step repeats the held pixel, masked
                flags_next = '{we_ok: 1'b0, last: 1'b1};
            end else begin
                cur_row_next = row_adv;
                cur_col_next = col_adv;
                dec_next     = dec_adv;
                active_next  = !last_adv;
                flags_next   = '{we_ok: 1'b1, last: last_adv};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            stop_reg    <= '0;
            dec_reg     <= '0;
            inc_s_reg   <= '0;
            inc_g_reg   <= '0;
            slope_reg   <= SLOPE_FLAT;
            color_reg   <= '0;
            active_reg  <= 1'b0;
            valid_reg   <= 1'b0;
            flags_reg   <= '0;
        end else begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            stop_reg    <= stop_next;
            dec_reg     <= dec_next;
            inc_s_reg   <= inc_s_next;
            inc_g_reg   <= inc_g_next;
            slope_reg   <= slope_next;
            color_reg   <= color_next;
            active_reg  <= active_next;
            valid_reg   <= valid_next;
            flags_reg   <= flags_next;
        end
    end

    // the emitted pixel is the state after the update
    assign pix_valid = valid_reg;
    assign pix_row   = cur_row_reg;
    assign pix_col   = cur_col_reg;
    assign pix_color = color_reg;
    assign pix_flags = flags_reg;

endmodule

// ===== rtl/mlr_emit.sv =====
// ----------------------------------------------------------------------------
// mlr_emit: pixel output stage
// Forms the frame address and the interior-window write enable and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module mlr_emit #(
    parameter int COORD_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  logic signed [COORD_BITS-1:0]      pix_row,
    input  logic signed [COORD_BITS-1:0]      pix_col,
    input  logic [mlr_pkg::COLOR_BITS-1:0]    pix_color,
    input  mlr_pkg::pix_flags_t               pix_flags,
    input  logic [mlr_pkg::DIM_BITS-1:0]      screen_width,
    input  logic [mlr_pkg::DIM_BITS-1:0]      screen_height,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COORD_BITS-1:0]      out_row,
    output logic signed [COORD_BITS-1:0]      out_col,
    output logic [mlr_pkg::ADDR_BITS-1:0]     out_addr,
    output logic [mlr_pkg::COLOR_BITS-1:0]    out_color,
    output logic                              out_we,
    output logic                              out_last
);
    import mlr_pkg::*;

    localparam int CW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
    localparam logic signed [CW-1:0] ONE_X = 1;

    logic                          valid_reg;
    logic signed [COORD_BITS-1:0]  row_reg, col_reg;
    logic [ADDR_BITS-1:0]          addr_reg;
    logic [COLOR_BITS-1:0]         color_reg;
    logic                          we_reg, last_reg;

    logic signed [CW-1:0]          row_x, col_x, w_x, h_x;
    logic [ADDR_BITS-1:0]          row_a, col_a, addr;
    logic                          in_window;
    logic                          load;

    assign row_x = CW'(pix_row);
    assign col_x = CW'(pix_col);
    assign w_x   = CW'(screen_width);
    assign h_x   = CW'(screen_height);

    // interior window: 1 <= row <= height-2, 1 <= col <= width-2
    assign in_window = (row_x > 0) && ((row_x + ONE_X) < h_x)
                    && (col_x > 0) && ((col_x + ONE_X) < w_x);

    assign row_a = ADDR_BITS'(pix_row);
    assign col_a = ADDR_BITS'(pix_col);
    assign addr  = col_a + ADDR_BITS'(screen_width) * row_a;

    assign pix_ready = !valid_reg || out_ready;
    assign load      = pix_valid && pix_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pix_ready) begin
            valid_reg <= pix_valid;
        end
        if (load) begin
            row_reg   <= pix_row;
            col_reg   <= pix_col;
            addr_reg  <= addr;
            color_reg <= pix_color;
            we_reg    <= pix_flags.we_ok && in_window;
            last_reg  <= pix_flags.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_addr  = addr_reg;
    assign out_color = color_reg;
    assign out_we    = we_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/mlr_checker.sv =====
// ----------------------------------------------------------------------------
// mlr_checker: port-level checks for the line rasterizer
// Watches the stream ports for reset, held stalled results, results against
// requests and the write-enable window; bound to the top level below.
// ----------------------------------------------------------------------------
module mlr_checker #(
    parameter  int COORD_BITS = 16,
    localparam int OUT_BITS   =
        ((2 * COORD_BITS + mlr_pkg::ADDR_BITS + mlr_pkg::COLOR_BITS + 7) / 8) * 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);
    // requests held inside: front stage, two queue slots, engine, output
    localparam logic [2:0] MAX_INFLIGHT = 3'd5;

    logic [2:0] inflight_reg, inflight_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    a_no_result_without_request: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> inflight_reg != '0)
        else $error("result taken with no request outstanding");

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= MAX_INFLIGHT)
        else $error("more requests held than the pipeline has room for");

    a_write_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> ($signed(m_tdata[COORD_BITS-1:0]) > 0)
                                && ($signed(m_tdata[2*COORD_BITS-1:COORD_BITS]) > 0))
        else $error("write enable outside the interior window");

endmodule

bind midpoint_line_rasterizer mlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_mlr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
